/* src/loki97_block_cipher_defines.svh */
// Assertion helpers for the LOKI97 core.
`ifndef LOKI97_BLOCK_CIPHER_DEFINES_SVH
`define LOKI97_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define LOKI97_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LOKI97_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/loki97_pkg.sv */
package loki97_pkg;

	localparam int ROUNDS         = 16;
	localparam int SCHEDULE_STEPS = 48;

	localparam logic [63:0] GOLDEN_DELTA = 64'h9E3779B97F4A7C15;
	localparam logic [13:0] POLY13       = 14'h2911;
	localparam logic [11:0] POLY11       = 12'hAA7;

	localparam logic CMD_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_KEY,
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		REG_KEY_A,
		REG_KEY_B,
		REG_KEY_C,
		REG_KEY_D
	} reg_idx_t;

	// GF(2^13) multiply: carry-less product, then reduce from the top bit down.
	function automatic logic [12:0] gf13_mul(logic [12:0] a, logic [12:0] b);
		logic [24:0] prod;
		prod = '0;
		for (int i = 0; i < 13; i++) begin
			if (b[i]) prod = prod ^ (25'(a) << i);
		end
		for (int i = 24; i >= 13; i--) begin
			if (prod[i]) prod = prod ^ (25'(POLY13) << (i - 13));
		end
		return prod[12:0];
	endfunction

	function automatic logic [10:0] gf11_mul(logic [10:0] a, logic [10:0] b);
		logic [20:0] prod;
		prod = '0;
		for (int i = 0; i < 11; i++) begin
			if (b[i]) prod = prod ^ (21'(a) << i);
		end
		for (int i = 20; i >= 11; i--) begin
			if (prod[i]) prod = prod ^ (21'(POLY11) << (i - 11));
		end
		return prod[10:0];
	endfunction

	// S1: (x ^ 1FFF)^3 in GF(2^13), low byte
	function automatic logic [7:0] sbox13(logic [12:0] x);
		logic [12:0] v;
		logic [12:0] c;
		v = x ^ 13'h1FFF;
		c = gf13_mul(gf13_mul(v, v), v);
		return c[7:0];
	endfunction

	// S2: (x ^ 7FF)^3 in GF(2^11), low byte
	function automatic logic [7:0] sbox11(logic [10:0] x);
		logic [10:0] v;
		logic [10:0] c;
		v = x ^ 11'h7FF;
		c = gf11_mul(gf11_mul(v, v), v);
		return c[7:0];
	endfunction

endpackage

/* src/loki97_ifs.sv */
interface loki97_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [63:0] data_left;
	logic [63:0] data_right;

	modport source (output valid, output cmd, output data_left, output data_right,
		input ready);
	modport sink (input valid, input cmd, input data_left, input data_right,
		output ready);
endinterface

interface loki97_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_left;
	logic [63:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

/* src/loki97_block_cipher.sv */
// ---------------------------------------------------------------------------
//  channel  dir   handshake       payload
//  din      in    valid/ready     cmd, data_left, data_right
//  dout     out   valid/ready     out_left, out_right
//  apb      in    psel/penable    key_a..key_d at 0x00/0x08/0x10/0x18, 64-bit
//
//  A block runs all 16 rounds in ST_RUN; each round reads its three subkeys
//  in turn from the subkey memory, forms the F input, loads the F unit and
//  updates both halves. ST_DONE hands the result to the output register and
//  din.ready only returns in ST_IDLE, so a new block is not taken before the
//  last one is through. The round rate is set by the single-read-port subkey
//  memory (three subkeys a round) feeding the shared two-stage F unit.
//  After reset and after every key write the schedule is re-expanded: 48
//  steps on the same F unit, with din.ready low.
//  The result waits in the output register; while it is not taken the core
//  finishes the next block but holds it until the register frees up.
// ---------------------------------------------------------------------------
`include "loki97_block_cipher_defines.svh"

module loki97_block_cipher (
	input  logic               clk,
	input  logic               arst_n,
	loki97_in_if.sink          din,
	loki97_out_if.source       dout,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import loki97_pkg::*;

	localparam logic [5:0] LAST_STEP = 6'(SCHEDULE_STEPS - 1);
	localparam logic [5:0] LAST_RND  = 6'(ROUNDS - 1);

	state_t      state_q, state_d;
	logic [1:0]  ph_q;
	logic [5:0]  cnt_q;

	// key registers
	logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q;
	// schedule working words
	logic [63:0] k1_q, k2_q, k3_q, k4_q, del_q;

	// block datapath
	logic        cmd_q;
	logic [63:0] lh_q, rh_q, x_q, rd_q;
	logic [63:0] ol_q, or_q;
	logic        out_valid_q;

	logic [63:0] sk_mem [SCHEDULE_STEPS];

	logic        cfg_wr;
	reg_idx_t    cfg_idx;
	logic        in_acc;
	logic        out_go;
	logic        enc;
	logic [3:0]  rnd;
	logic [1:0]  off;
	logic [5:0]  rd_addr;
	logic        fn_load;
	logic [63:0] fn_key;
	logic [63:0] fn_res;
	logic [63:0] nk1;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);
	assign enc     = (cmd_q != CMD_DECRYPT);
	assign nk1     = k4_q ^ fn_res;

	always_comb begin
		unique case (cfg_idx)
			REG_KEY_A: prdata = key_a_q;
			REG_KEY_B: prdata = key_b_q;
			REG_KEY_C: prdata = key_c_q;
			REG_KEY_D: prdata = key_d_q;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_KEY:  if (ph_q == 2'd2 && cnt_q == LAST_STEP) state_d = ST_IDLE;
			ST_IDLE: if (din.valid) state_d = ST_RUN;
			ST_RUN:  if (ph_q == 2'd3 && cnt_q == LAST_RND) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || dout.ready) state_d = ST_IDLE;
		endcase
		if (cfg_wr) state_d = ST_KEY;
	end

	// outputs of the sequencer
	always_comb begin
		din.ready = 1'b0;
		out_go    = 1'b0;
		fn_load   = 1'b0;
		unique case (state_q)
			ST_KEY:  fn_load = (ph_q == 2'd1);
			ST_IDLE: din.ready = 1'b1;
			ST_RUN:  fn_load = (ph_q == 2'd2);
			ST_DONE: out_go = !out_valid_q || dout.ready;
		endcase
	end

	assign in_acc = din.valid & din.ready;
	assign fn_key = (state_q == ST_KEY) ? k2_q : rd_q;

	// subkey address: encrypt reads 3r, 3r+1, 3r+2; decrypt the reverse order
	assign rnd     = enc ? cnt_q[3:0] : (4'(ROUNDS - 1) - cnt_q[3:0]);
	assign off     = enc ? ph_q : (2'd2 - ph_q);
	assign rd_addr = {1'b0, rnd, 1'b0} + {2'b00, rnd} + {4'b0000, off};

	loki97_fn u_fn (
		.clk    (clk),
		.load   (fn_load),
		.arg_a  (x_q),
		.key    (fn_key),
		.result (fn_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KEY;
			ph_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr || state_d != state_q) begin
				ph_q  <= '0;
				cnt_q <= '0;
			end else if (state_q == ST_KEY) begin
				if (ph_q == 2'd2) begin
					ph_q  <= '0;
					cnt_q <= cnt_q + 6'd1;
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end else if (state_q == ST_RUN) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	// key registers and schedule words; reset expands the all-zero key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_a_q <= '0;
			key_b_q <= '0;
			key_c_q <= '0;
			key_d_q <= '0;
			k1_q    <= '0;
			k2_q    <= '0;
			k3_q    <= '0;
			k4_q    <= '0;
			del_q   <= GOLDEN_DELTA;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_KEY_A: key_a_q <= pwdata;
				REG_KEY_B: key_b_q <= pwdata;
				REG_KEY_C: key_c_q <= pwdata;
				REG_KEY_D: key_d_q <= pwdata;
			endcase
			k4_q  <= (cfg_idx == REG_KEY_A) ? pwdata : key_a_q;
			k3_q  <= (cfg_idx == REG_KEY_B) ? pwdata : key_b_q;
			k2_q  <= (cfg_idx == REG_KEY_C) ? pwdata : key_c_q;
			k1_q  <= (cfg_idx == REG_KEY_D) ? pwdata : key_d_q;
			del_q <= GOLDEN_DELTA;
		end else if (state_q == ST_KEY && ph_q == 2'd2) begin
			k4_q  <= k3_q;
			k3_q  <= k2_q;
			k2_q  <= k1_q;
			k1_q  <= nk1;
			del_q <= del_q + GOLDEN_DELTA;
		end
	end

	// subkey store
	always_ff @(posedge clk) begin
		if (state_q == ST_KEY && ph_q == 2'd2) sk_mem[cnt_q] <= nk1;
		rd_q <= sk_mem[rd_addr];
	end

	// rounds
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= din.cmd;
			if (din.cmd != CMD_DECRYPT) begin
				lh_q <= din.data_left;
				rh_q <= din.data_right;
			end else begin
				rh_q <= din.data_left;
				lh_q <= din.data_right;
			end
		end
		if (state_q == ST_KEY && ph_q == 2'd0) x_q <= k1_q + k3_q + del_q;
		if (state_q == ST_RUN && ph_q == 2'd1) x_q <= enc ? (rh_q + rd_q) : (lh_q - rd_q);
		if (state_q == ST_RUN && ph_q == 2'd3) begin
			if (enc) begin
				rh_q <= lh_q ^ fn_res;
				lh_q <= x_q + rd_q;
			end else begin
				lh_q <= rh_q ^ fn_res;
				rh_q <= x_q - rd_q;
			end
		end
		if (out_go) begin
			ol_q <= enc ? rh_q : lh_q;
			or_q <= enc ? lh_q : rh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_go) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.out_left  = ol_q;
	assign dout.out_right = or_q;

	`LOKI97_ASSERT_NEXT(a_key_restart, cfg_wr, state_q == ST_KEY && ph_q == 2'd0 && cnt_q == 6'd0, "key write did not restart schedule")
	`LOKI97_ASSERT_NEXT(a_block_start, in_acc && !cfg_wr, state_q == ST_RUN && ph_q == 2'd0 && cnt_q == 6'd0, "block did not start at round zero")
	`LOKI97_ASSERT_NEXT(a_last_round, state_q == ST_RUN && ph_q == 2'd3 && cnt_q == LAST_RND && !cfg_wr, state_q == ST_DONE, "missing done after last round")
	`LOKI97_ASSERT_NEXT(a_sched_end, state_q == ST_KEY && ph_q == 2'd2 && cnt_q == LAST_STEP && !cfg_wr, state_q == ST_IDLE, "schedule did not finish after last step")

endmodule

/* src/loki97_fn.sv */
// Two-stage F function: keyed swap + first S-box layer + permutation into p_s1,
// second S-box layer combinational from p_s1 and the saved high key word.
module loki97_fn (
	input  logic        clk,
	input  logic        load,
	input  logic [63:0] arg_a,
	input  logic [63:0] key,
	output logic [63:0] result
);
	import loki97_pkg::*;

	localparam int SA_KIND[8]  = '{1, 2, 1, 2, 2, 1, 2, 1};
	localparam int SA_START[8] = '{56, 48, 40, 32, 24, 16, 8, 0};
	localparam int SB_W[8]     = '{3, 3, 5, 5, 3, 3, 5, 5};
	localparam int SB_USED[8]  = '{3, 6, 11, 16, 19, 22, 27, 32};

	logic [63:0]  p_s1;
	logic [31:0]  kl_s1;
	logic [63:0]  layer_a;
	logic [63:0]  swapped;
	logic [127:0] dbl;
	logic [31:0]  kr;
	logic [31:0]  al;
	logic [31:0]  ar;

	always_comb begin
		logic [12:0] win;
		logic [7:0]  s;
		kr = key[31:0];
		al = arg_a[63:32];
		ar = arg_a[31:0];
		swapped = {(al & ~kr) | (ar & kr), (ar & ~kr) | (al & kr)};
		dbl = {swapped, swapped};
		layer_a = '0;
		for (int k = 0; k < 8; k++) begin
			// rotate-right window, wrapping through the upper copy
			win = dbl[SA_START[k] +: 13];
			s = (SA_KIND[k] == 1) ? sbox13(win) : sbox11(win[10:0]);
			for (int b = 0; b < 8; b++) begin
				layer_a[8 * b + 7 - k] = s[b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			p_s1  <= layer_a;
			kl_s1 <= key[63:32];
		end
	end

	always_comb begin
		logic [4:0]  kb;
		logic [7:0]  pb;
		logic [12:0] idx;
		result = '0;
		for (int k = 0; k < 8; k++) begin
			kb  = 5'((kl_s1 >> (32 - SB_USED[k])) & ((32'd1 << SB_W[k]) - 32'd1));
			pb  = p_s1[56 - 8 * k +: 8];
			idx = {kb, pb};
			result[56 - 8 * k +: 8] = (SB_W[k] == 5) ? sbox13(idx) : sbox11(idx[10:0]);
		end
	end

endmodule

/* test/loki97_block_cipher_checker.sv */
`timescale 1ns / 100ps

module loki97_block_cipher_checker (
	input  logic        clk,
	input  logic        arst_n,
	loki97_in_if        din,
	loki97_out_if       dout,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);
	import loki97_pkg::*;

	typedef struct packed {
		logic [63:0] left;
		logic [63:0] right;
	} block_t;

	logic [7:0]  cube13 [8192];
	logic [7:0]  cube11 [2048];
	logic [63:0] key_words [4];
	logic [63:0] round_keys [SCHEDULE_STEPS];
	block_t      blocks_due [$];

	assign pending = blocks_due.size();

	function automatic int unsigned field_mul(int unsigned a, int unsigned b, int unsigned w,
		int unsigned poly);
		int unsigned acc;
		acc = 0;
		while (b != 0) begin
			if (b[0]) acc ^= a;
			b >>= 1;
			a <<= 1;
			if (a & (1 << w)) a ^= poly;
		end
		return acc;
	endfunction

	initial begin
		int unsigned v;
		for (int i = 0; i < 8192; i++) begin
			v = i ^ 'h1FFF;
			cube13[i] = 8'(field_mul(field_mul(v, v, 13, 'h2911), v, 13, 'h2911));
		end
		for (int i = 0; i < 2048; i++) begin
			v = i ^ 'h7FF;
			cube11[i] = 8'(field_mul(field_mul(v, v, 11, 'hAA7), v, 11, 'hAA7));
		end
	end

	// round function: keyed swap, S-layer, bit permutation, keyed S-layer
	function automatic logic [63:0] round_mix(logic [63:0] a, logic [63:0] b);
		logic [31:0]  kr, kl;
		logic [63:0]  t, p, r;
		logic [127:0] dbl;
		logic [7:0]   s;
		logic [12:0]  idx;
		int           used, w;
		kr = b[31:0];
		kl = b[63:32];
		t = {(a[63:32] & ~kr) | (a[31:0] & kr), (a[31:0] & ~kr) | (a[63:32] & kr)};
		p = '0;
		r = '0;
		used = 0;
		for (int k = 0; k < 8; k++) begin
			dbl = {t, t} >> (56 - 8 * k);
			// windows alternate large, small, ... with a swap in the middle
			if (k == 0 || k == 2 || k == 5 || k == 7) s = cube13[dbl[12:0]];
			else s = cube11[dbl[10:0]];
			for (int bt = 0; bt < 8; bt++) p[8 * bt + 7 - k] = s[bt];
		end
		for (int k = 0; k < 8; k++) begin
			w = (k == 2 || k == 3 || k == 6 || k == 7) ? 5 : 3;
			used += w;
			idx = 13'(((kl >> (32 - used)) & ((1 << w) - 1)) << 8) | 13'(p[56 - 8 * k +: 8]);
			s = (w == 5) ? cube13[idx] : cube11[idx[10:0]];
			r[56 - 8 * k +: 8] = s;
		end
		return r;
	endfunction

	function automatic void schedule_keys();
		logic [63:0] k1, k2, k3, k4, del, nk;
		k4 = key_words[REG_KEY_A];
		k3 = key_words[REG_KEY_B];
		k2 = key_words[REG_KEY_C];
		k1 = key_words[REG_KEY_D];
		del = GOLDEN_DELTA;
		for (int i = 0; i < SCHEDULE_STEPS; i++) begin
			nk = k4 ^ round_mix(k1 + k3 + del, k2);
			del += GOLDEN_DELTA;
			k4 = k3;
			k3 = k2;
			k2 = k1;
			k1 = nk;
			round_keys[i] = nk;
		end
	endfunction

	function automatic block_t cipher_block(logic dec, logic [63:0] in_l, logic [63:0] in_r);
		logic [63:0] lh, rh, t, nl;
		block_t res;
		if (dec != CMD_DECRYPT) begin
			lh = in_l;
			rh = in_r;
			for (int q = 0; q < ROUNDS; q++) begin
				t = rh + round_keys[3 * q];
				nl = t + round_keys[3 * q + 2];
				rh = lh ^ round_mix(t, round_keys[3 * q + 1]);
				lh = nl;
			end
			res.left = rh;
			res.right = lh;
		end else begin
			rh = in_l;
			lh = in_r;
			for (int q = ROUNDS - 1; q >= 0; q--) begin
				t = lh - round_keys[3 * q + 2];
				nl = rh ^ round_mix(t, round_keys[3 * q + 1]);
				rh = t - round_keys[3 * q];
				lh = nl;
			end
			res.left = lh;
			res.right = rh;
		end
		return res;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
		fails++;
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		block_t want;
		if (!arst_n) begin
			foreach (key_words[i]) key_words[i] = '0;
			blocks_due.delete();
			schedule_keys();
		end else begin
			if (psel && penable && pwrite && pready) begin
				key_words[reg_idx_t'(paddr[4:3])] = pwdata;
				schedule_keys();
			end
			if (din.valid && din.ready)
				blocks_due.push_back(cipher_block(din.cmd, din.data_left, din.data_right));
			if (dout.valid && dout.ready) begin
				if (blocks_due.size() == 0) begin
					$display("%0t: result transaction with nothing outstanding", $realtime);
					fails++;
				end else begin
					want = blocks_due.pop_front();
					if (dout.out_left !== want.left) report("out_left", dout.out_left, want.left);
					if (dout.out_right !== want.right)
						report("out_right", dout.out_right, want.right);
				end
			end
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import loki97_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata, prdata;
	logic        pready;
	int          fails, pending;

	// no_idle: phases where both sides run flat out
	bit          no_idle;
	logic [63:0] past_l [$];
	logic [63:0] past_r [$];

	loki97_in_if  din ();
	loki97_out_if dout ();

	loki97_block_cipher DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din.sink),
		.dout    (dout.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	loki97_block_cipher_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.dout    (dout),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 60);
	endfunction

	// result side: random back-pressure, driven at the rising edge
	int stall_cnt;
	always @(posedge clk) begin
		if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			dout.ready <= 1'b0;
		end else begin
			stall_cnt <= idle_len();
			dout.ready <= 1'b1;
		end
	end

	// one block transaction; valid stays high into the next call when there is no gap
	task automatic send_block(logic c, logic [63:0] l, logic [63:0] r);
		bit took;
		int gap;
		din.valid <= 1'b1;
		din.cmd <= c;
		din.data_left <= l;
		din.data_right <= r;
		took = 0;
		while (!took) begin
			@(negedge clk);
			took = din.ready;
			@(posedge clk);
		end
		past_l.push_back(l);
		past_r.push_back(r);
		if (past_l.size() > 16) begin
			void'(past_l.pop_front());
			void'(past_r.pop_front());
		end
		gap = idle_len();
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain outstanding blocks so the key may change
	task automatic settle();
		din.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// APB write: setup then access phase, then back to idle
	task automatic write_key(reg_idx_t idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic directed_set();
		send_block(1'b0, '0, '0);
		send_block(1'b0, '1, '1);
		send_block(1'b1, '0, '0);
		send_block(1'b1, '1, '1);
		send_block(1'b0, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		send_block(1'b1, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
	endtask

	initial begin
		int n_items;
		int pick;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		din.valid = 1'b0;
		din.cmd = 1'b0;
		din.data_left = '0;
		din.data_right = '0;
		dout.ready = 1'b0;
		stall_cnt = 0;
		no_idle = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero key from reset, then all-ones and mixed keys
		directed_set();
		settle();
		for (int i = 0; i < 4; i++) write_key(reg_idx_t'(i), '1);
		directed_set();
		settle();
		write_key(REG_KEY_A, 64'h0001020304050607);
		write_key(REG_KEY_B, 64'h08090A0B0C0D0E0F);
		write_key(REG_KEY_C, 64'h1011121314151617);
		write_key(REG_KEY_D, 64'h18191A1B1C1D1E1F);
		directed_set();
		send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
		send_block(1'b1, 64'h0000000000000001, 64'h8000000000000000);

		// random phases; the first two rewrite every key word, later ones a random subset
		for (int ph = 0; ph < 14; ph++) begin
			settle();
			no_idle = (ph % 4 == 3);
			for (int i = 0; i < 4; i++)
				if (ph < 2 || $urandom_range(0, 1)) begin
					pick = $urandom_range(0, 5);
					write_key(reg_idx_t'(i), pick == 0 ? 64'h0 : pick == 1 ? '1 : rand64());
				end
			n_items = $urandom_range(70, 110);
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 3 && past_l.size() > 0) begin
					// resend a recent block with a random command
					pick = $urandom_range(0, past_l.size() - 1);
					send_block(1'($urandom), past_l[pick], past_r[pick]);
				end else
					send_block(1'($urandom), rand64(), rand64());
			end
		end

		din.valid <= 1'b0;
		for (int w = 0; w < 200000 && pending != 0; w++) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("loki97_block_cipher test passed");
		end else begin
			$display("loki97_block_cipher test failed");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("loki97_block_cipher test failed");
		$finish;
	end

endmodule

/* loki97_block_cipher.f */
+incdir+src
src/loki97_pkg.sv
src/loki97_ifs.sv
src/loki97_fn.sv
src/loki97_block_cipher.sv
test/loki97_block_cipher_checker.sv
test/tb.sv
